@@ design/rbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_AXES      = 3;
   localparam int NUM_CFG       = 6;
   localparam int CSR_IDX_W     = 3;

   localparam logic signed [DATA_W-1:0] T_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] T_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_LOW_X  = 3'd0,
      CSR_BOX_LOW_Y  = 3'd1,
      CSR_BOX_LOW_Z  = 3'd2,
      CSR_BOX_HIGH_X = 3'd3,
      CSR_BOX_HIGH_Y = 3'd4,
      CSR_BOX_HIGH_Z = 3'd5
   } csr_index_type;

   // sideband that travels alongside the dividers
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] closest;
      logic [NUM_AXES-1:0]      par;
      logic [NUM_AXES-1:0]      par_miss;
      logic [2*NUM_AXES-1:0]    neg;
   } side_type;

endpackage

@@ design/rbsi_divider.sv @@
// ----------------------------------------------------------------------------
// rbsi_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag for quotients of 2^32 or more.
// ----------------------------------------------------------------------------
module rbsi_divider
   import rbsi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [DATA_W+FRAC_BITS:0]   num,
   input  logic [DATA_W-1:0]           den,
   output logic [DATA_W-1:0]           quot,
   output logic                        ovf
);

   localparam int NW = DATA_W + FRAC_BITS + 1;
   localparam int QW = DATA_W;

   logic [NW-1:0] rem_ff [0:QW-1];
   logic [QW-1:0] den_ff [0:QW-1];
   logic [QW-1:0] quo_ff [0:QW];
   logic          ovf_ff [0:QW];
   logic          ovf_in;

   assign ovf_in = (QW+1)'(num[NW-1:QW]) >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int SH = QW - 1 - k;
      logic          ge;
      logic [NW-1:0] sub;
      logic [QW-1:0] quo_in;

      always_comb begin
         ge     = (rem_ff[k] >> SH) >= NW'(den_ff[k]);
         sub    = rem_ff[k] - (NW'(den_ff[k]) << SH);
         quo_in = quo_ff[k];
         quo_in[SH] = ge;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k+1] <= quo_in;
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end

      if (k < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k+1] <= ge ? sub : rem_ff[k];
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   assign quot = quo_ff[QW];
   assign ovf  = ovf_ff[QW];

endmodule

@@ design/ray_box_slab_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray versus axis-aligned box test, slab method, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Box bounds sit in six registers written through the csr_ port (index 0..5:
//   low x,y,z then high x,y,z); writes to other indexes are dropped. Write
//   them only while the pipeline is empty.
//   req_ carries origin, direction and closest_t; one transfer per cycle is
//   taken while req_ready is high. rsp_ returns hit and entry_t (entry
//   distance on a hit, else closest_t) in request order.
//   A request passes through one input stage, six pipelined dividers (one
//   quotient bit per stage), a saturation stage, an ordering stage and the
//   output register before its response is valid.
//   Throughput is one item per cycle while the receiver does not stall.
//   Reset clears the box registers to zero and empties the pipeline.
//   When the receiver stalls the whole pipeline holds and req_ready drops;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect
   import rbsi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_origin_x,
   input  logic signed [DATA_W-1:0] req_origin_y,
   input  logic signed [DATA_W-1:0] req_origin_z,
   input  logic signed [DATA_W-1:0] req_dir_x,
   input  logic signed [DATA_W-1:0] req_dir_y,
   input  logic signed [DATA_W-1:0] req_dir_z,
   input  logic signed [DATA_W-1:0] req_closest_t,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_entry_t
);

   localparam int NW      = DATA_W + FRAC_BITS + 1;
   localparam int DIV_LAT = DATA_W + 1;
   localparam int ND      = 2 * NUM_AXES;

   logic signed [DATA_W-1:0] cfg_ff [0:NUM_CFG-1];
   logic                     adv;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) cfg_ff[i] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BOX_LOW_X:  cfg_ff[0] <= csr_write_data;
            CSR_BOX_LOW_Y:  cfg_ff[1] <= csr_write_data;
            CSR_BOX_LOW_Z:  cfg_ff[2] <= csr_write_data;
            CSR_BOX_HIGH_X: cfg_ff[3] <= csr_write_data;
            CSR_BOX_HIGH_Y: cfg_ff[4] <= csr_write_data;
            CSR_BOX_HIGH_Z: cfg_ff[5] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input stage: slab differences, magnitudes and signs
   logic signed [DATA_W-1:0] org [0:NUM_AXES-1];
   logic signed [DATA_W-1:0] dir [0:NUM_AXES-1];
   side_type                 s0_in, s0_ff;
   logic [NW-1:0]            num_in [0:ND-1];
   logic [NW-1:0]            num_ff [0:ND-1];
   logic [DATA_W-1:0]        den_in [0:NUM_AXES-1];
   logic [DATA_W-1:0]        den_ff [0:NUM_AXES-1];

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   always_comb begin
      logic signed [DATA_W:0] diff;
      logic [DATA_W:0]        mag;
      s0_in.valid   = req_valid;
      s0_in.closest = req_closest_t;
      for (int a = 0; a < NUM_AXES; a++) begin
         s0_in.par[a]      = dir[a] == '0;
         s0_in.par_miss[a] = s0_in.par[a] &&
                             (org[a] < cfg_ff[a] || org[a] > cfg_ff[NUM_AXES+a]);
         den_in[a] = dir[a][DATA_W-1] ? DATA_W'(-dir[a]) : DATA_W'(dir[a]);
      end
      for (int j = 0; j < ND; j++) begin
         diff = (DATA_W+1)'(cfg_ff[j]) - (DATA_W+1)'(org[j % NUM_AXES]);
         mag  = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
         num_in[j]   = NW'(mag) << FRAC_BITS;
         s0_in.neg[j] = diff[DATA_W] != dir[j % NUM_AXES][DATA_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff.valid <= s0_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff.closest  <= s0_in.closest;
         s0_ff.par      <= s0_in.par;
         s0_ff.par_miss <= s0_in.par_miss;
         s0_ff.neg      <= s0_in.neg;
         num_ff         <= num_in;
         den_ff         <= den_in;
      end
   end

   // dividers and matching sideband line
   logic [DATA_W-1:0] quot [0:ND-1];
   logic              ovf  [0:ND-1];
   side_type          side_ff [0:DIV_LAT-1];

   for (genvar j = 0; j < ND; j++) begin : g_div
      rbsi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock  (clock),
         .enable (adv),
         .num    (num_ff[j]),
         .den    (den_ff[j % NUM_AXES]),
         .quot   (quot[j]),
         .ovf    (ovf[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) side_ff[i].valid <= 1'b0;
      end else if (adv) begin
         side_ff[0].valid <= s0_ff.valid;
         for (int i = 1; i < DIV_LAT; i++) side_ff[i].valid <= side_ff[i-1].valid;
      end
      if (adv) begin
         side_ff[0].closest  <= s0_ff.closest;
         side_ff[0].par      <= s0_ff.par;
         side_ff[0].par_miss <= s0_ff.par_miss;
         side_ff[0].neg      <= s0_ff.neg;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i].closest  <= side_ff[i-1].closest;
            side_ff[i].par      <= side_ff[i-1].par;
            side_ff[i].par_miss <= side_ff[i-1].par_miss;
            side_ff[i].neg      <= side_ff[i-1].neg;
         end
      end
   end

   // saturation stage
   logic signed [DATA_W-1:0] t_in [0:ND-1];
   logic signed [DATA_W-1:0] t_ff [0:ND-1];
   side_type                 sat_ff;

   always_comb begin
      for (int j = 0; j < ND; j++) begin
         if (side_ff[DIV_LAT-1].neg[j]) begin
            t_in[j] = (ovf[j] || quot[j] > DATA_W'(T_MIN)) ? T_MIN : -quot[j];
         end else begin
            t_in[j] = (ovf[j] || quot[j][DATA_W-1]) ? T_MAX : quot[j];
         end
      end
   end

   // ordering stage
   logic signed [DATA_W-1:0] ent_in [0:NUM_AXES-1];
   logic signed [DATA_W-1:0] ext_in [0:NUM_AXES-1];
   logic signed [DATA_W-1:0] ent_ff [0:NUM_AXES-1];
   logic signed [DATA_W-1:0] ext_ff [0:NUM_AXES-1];
   side_type                 ord_ff;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (sat_ff.par[a]) begin
            ent_in[a] = T_MIN;
            ext_in[a] = T_MAX;
         end else if (t_ff[a] > t_ff[NUM_AXES+a]) begin
            ent_in[a] = t_ff[NUM_AXES+a];
            ext_in[a] = t_ff[a];
         end else begin
            ent_in[a] = t_ff[a];
            ext_in[a] = t_ff[NUM_AXES+a];
         end
      end
   end

   // output stage
   logic signed [DATA_W-1:0] near_t, far_t;
   logic                     hit_in;
   logic                     rsp_valid_ff, rsp_hit_ff;
   logic signed [DATA_W-1:0] rsp_entry_t_ff;

   always_comb begin
      near_t = ent_ff[0];
      far_t  = ext_ff[0];
      for (int a = 1; a < NUM_AXES; a++) begin
         if (ent_ff[a] > near_t) near_t = ent_ff[a];
         if (ext_ff[a] < far_t)  far_t  = ext_ff[a];
      end
      hit_in = !(|ord_ff.par_miss) && near_t <= ord_ff.closest &&
               near_t <= far_t && !far_t[DATA_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff.valid <= 1'b0;
         ord_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         sat_ff.valid <= side_ff[DIV_LAT-1].valid;
         ord_ff.valid <= sat_ff.valid;
         rsp_valid_ff <= ord_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sat_ff.closest  <= side_ff[DIV_LAT-1].closest;
         sat_ff.par      <= side_ff[DIV_LAT-1].par;
         sat_ff.par_miss <= side_ff[DIV_LAT-1].par_miss;
         sat_ff.neg      <= side_ff[DIV_LAT-1].neg;
         t_ff            <= t_in;
         ord_ff.closest  <= sat_ff.closest;
         ord_ff.par      <= sat_ff.par;
         ord_ff.par_miss <= sat_ff.par_miss;
         ord_ff.neg      <= sat_ff.neg;
         ent_ff          <= ent_in;
         ext_ff          <= ext_in;
         rsp_hit_ff      <= hit_in;
         rsp_entry_t_ff  <= hit_in ? near_t : ord_ff.closest;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_entry_t = rsp_entry_t_ff;

   a_ready_tracks_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(ord_ff.valid) && $stable(sat_ff.valid) &&
                     $stable(side_ff[DIV_LAT-1].valid))
      else $error("pipeline moved during stall");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !s0_ff.valid)
      else $error("pipeline not empty after reset");

   a_miss_passes_closest: assert property (@(posedge clock) disable iff (reset)
      adv && ord_ff.valid && !hit_in |=> rsp_entry_t == $past(ord_ff.closest))
      else $error("miss did not pass closest_t through");

endmodule
